/* hw/rtl/lcs_pkg.sv */
// Shared types and constants of the lift controller scan unit.
`default_nettype none

package lcs_pkg;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_UP      = 2'd1,
      MODE_DOWN    = 2'd2,
      MODE_SERVICE = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      DIR_STOP = 2'd0,
      DIR_UP   = 2'd1,
      DIR_DOWN = 2'd2
   } dir_type;

   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DOOR_HOLD_TICKS   = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OBSTRUCT_DISTANCE = 4'd1;

   localparam logic [15:0] DOOR_HOLD_RESET = 16'd60;
   localparam logic [9:0]  OBSTRUCT_RESET  = 10'd10;
   localparam logic [15:0] COUNTER_MAX     = 16'hFFFF;

   // Only the three lowest floors have limit switches.
   localparam int SWITCH_COUNT = 3;

   typedef struct packed {
      logic [2:0] floor_switches;
      logic       request_valid;
      logic [3:0] request_floor;
      logic [9:0] door_distance;
   } req_type;

   typedef struct packed {
      logic       motor_up;
      logic       motor_down;
      logic       door_open;
      logic [1:0] floor_now;
      logic [1:0] mode;
      logic [2:0] pending;
   } rsp_type;

   typedef struct packed {
      logic [15:0] door_hold_ticks;
      logic [9:0]  obstruct_distance;
   } cfg_type;

   typedef struct packed {
      mode_type    lift_mode;
      dir_type     motor_dir;
      logic        prefer_up;
      logic [15:0] door_counter;
   } ctrl_type;

endpackage

`default_nettype wire

/* hw/rtl/lcs_csr.sv */
// Configuration registers of the lift controller scan unit.
`default_nettype none

module lcs_csr (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_valid,
   output      logic                                  csr_ready,
   input  wire logic [lcs_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [lcs_pkg::CSR_DATA_WIDTH-1:0]    csr_data,
   output      lcs_pkg::cfg_type                      cfg
);

   lcs_pkg::cfg_type cfg_ff;
   lcs_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            lcs_pkg::CSR_DOOR_HOLD_TICKS: begin
               cfg_in.door_hold_ticks = csr_data;
            end
            lcs_pkg::CSR_OBSTRUCT_DISTANCE: begin
               cfg_in.obstruct_distance = csr_data[9:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.door_hold_ticks   <= lcs_pkg::DOOR_HOLD_RESET;
         cfg_ff.obstruct_distance <= lcs_pkg::OBSTRUCT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/lcs_step.sv */
// Next-state logic of the lift controller for one control tick.
`default_nettype none

module lcs_step #(
   parameter int FLOORS = 3,
   parameter int FW     = $clog2(FLOORS + 1)
) (
   input  wire lcs_pkg::req_type      item,
   input  wire lcs_pkg::cfg_type      cfg,
   input  wire lcs_pkg::ctrl_type     ctrl,
   input  wire logic [FW-1:0]         floor,
   input  wire logic [FLOORS-1:0]     requests,
   output      lcs_pkg::ctrl_type     ctrl_next,
   output      logic [FW-1:0]         floor_next,
   output      logic [FLOORS-1:0]     requests_next
);

   logic [FLOORS-1:0] latched;
   logic [FLOORS-1:0] at_floor;
   logic [FLOORS-1:0] above_floor;
   logic [FLOORS-1:0] below_floor;
   logic [FW-1:0]     seen_floor;
   logic              changed;
   logic              wanted_here;
   logic              any_above;
   logic              any_below;
   logic [15:0]       counter_inc;

   always_comb begin
      latched = requests;
      for (int f = 0; f < FLOORS; f++) begin
         if (item.request_valid && ({1'b0, item.request_floor} == 5'(f + 1))) begin
            latched[f] = 1'b1;
         end
      end
   end

   // The lowest pressed switch gives the floor; none pressed keeps the old one.
   always_comb begin
      seen_floor = floor;
      changed    = 1'b0;
      for (int i = lcs_pkg::SWITCH_COUNT - 1; i >= 0; i--) begin
         if ((i < FLOORS) && item.floor_switches[i]) begin
            seen_floor = FW'(i + 1);
         end
      end
      changed = (seen_floor != floor);
   end

   always_comb begin
      for (int f = 0; f < FLOORS; f++) begin
         at_floor[f]    = (seen_floor == FW'(f + 1));
         above_floor[f] = (FW'(f + 1) > seen_floor);
         below_floor[f] = (FW'(f + 1) < seen_floor);
      end
      wanted_here = |(latched & at_floor);
      any_above   = |(latched & above_floor);
      any_below   = |(latched & below_floor);
   end

   assign counter_inc = (ctrl.door_counter == lcs_pkg::COUNTER_MAX) ?
                        ctrl.door_counter : ctrl.door_counter + 16'd1;

   always_comb begin
      logic serve;
      serve         = 1'b0;
      ctrl_next     = ctrl;
      floor_next    = seen_floor;
      requests_next = latched;
      case (ctrl.lift_mode)
         lcs_pkg::MODE_IDLE: begin
            if (wanted_here) begin
               serve = 1'b1;
            end else if (ctrl.prefer_up) begin
               if (any_above) begin
                  ctrl_next.lift_mode = lcs_pkg::MODE_UP;
                  ctrl_next.motor_dir = lcs_pkg::DIR_UP;
               end else if (any_below) begin
                  ctrl_next.prefer_up = 1'b0;
                  ctrl_next.lift_mode = lcs_pkg::MODE_DOWN;
                  ctrl_next.motor_dir = lcs_pkg::DIR_DOWN;
               end
            end else begin
               if (any_below) begin
                  ctrl_next.lift_mode = lcs_pkg::MODE_DOWN;
                  ctrl_next.motor_dir = lcs_pkg::DIR_DOWN;
               end else if (any_above) begin
                  ctrl_next.prefer_up = 1'b1;
                  ctrl_next.lift_mode = lcs_pkg::MODE_UP;
                  ctrl_next.motor_dir = lcs_pkg::DIR_UP;
               end
            end
         end
         lcs_pkg::MODE_UP: begin
            if (changed && wanted_here) begin
               serve = 1'b1;
            end else if (seen_floor == FW'(FLOORS)) begin
               ctrl_next.motor_dir = lcs_pkg::DIR_STOP;
               ctrl_next.lift_mode = lcs_pkg::MODE_IDLE;
               ctrl_next.prefer_up = 1'b0;
            end
         end
         lcs_pkg::MODE_DOWN: begin
            if (changed && wanted_here) begin
               serve = 1'b1;
            end else if (seen_floor == FW'(1)) begin
               ctrl_next.motor_dir = lcs_pkg::DIR_STOP;
               ctrl_next.lift_mode = lcs_pkg::MODE_IDLE;
               ctrl_next.prefer_up = 1'b1;
            end
         end
         default: begin
            if (item.door_distance < cfg.obstruct_distance) begin
               ctrl_next.door_counter = 16'd0;
            end else begin
               ctrl_next.door_counter = counter_inc;
               if (counter_inc >= cfg.door_hold_ticks) begin
                  ctrl_next.lift_mode = lcs_pkg::MODE_IDLE;
               end
            end
         end
      endcase
      if (serve) begin
         ctrl_next.motor_dir    = lcs_pkg::DIR_STOP;
         ctrl_next.lift_mode    = lcs_pkg::MODE_SERVICE;
         ctrl_next.door_counter = 16'd0;
         requests_next          = latched & ~at_floor;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/lift_controller_scan_unit.sv */
// Top level of the lift controller scan unit: item register, control state and result register.
// An accepted item waits in the item register until the result register is free; then the
// result of its step is registered. Throughput: one item per cycle while results are taken;
// the next-state step between the item and result registers sets this figure.
// Reset is synchronous and active high: idle at floor 1, upward preference, door counter zero,
// no requests, motor stopped, door hold 60 ticks and obstruction distance 10 cm.
`default_nettype none

module lift_controller_scan_unit #(
   parameter int FLOORS = 3
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output      logic                                  req_ready,
   input  wire lcs_pkg::req_type                      req_data,
   output      logic                                  rsp_valid,
   input  wire logic                                  rsp_ready,
   output      lcs_pkg::rsp_type                      rsp_data,
   input  wire logic                                  csr_valid,
   output      logic                                  csr_ready,
   input  wire logic [lcs_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [lcs_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);

   localparam int FW = $clog2(FLOORS + 1);

   lcs_pkg::cfg_type  cfg;

   logic              item_valid_ff;
   lcs_pkg::req_type  item_ff;
   logic              rsp_valid_ff;
   lcs_pkg::rsp_type  rsp_ff;
   lcs_pkg::rsp_type  rsp_in;

   lcs_pkg::ctrl_type ctrl_ff;
   lcs_pkg::ctrl_type ctrl_in;
   logic [FW-1:0]     floor_ff;
   logic [FW-1:0]     floor_in;
   logic [FLOORS-1:0] requests_ff;
   logic [FLOORS-1:0] requests_in;
   logic [FLOORS+2:0] pending_wide;
   logic              advance;

   lcs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   lcs_step #(
      .FLOORS (FLOORS),
      .FW     (FW)
   ) u_step (
      .item          (item_ff),
      .cfg           (cfg),
      .ctrl          (ctrl_ff),
      .floor         (floor_ff),
      .requests      (requests_ff),
      .ctrl_next     (ctrl_in),
      .floor_next    (floor_in),
      .requests_next (requests_in)
   );

   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign pending_wide = {3'b000, requests_in};

   always_comb begin
      rsp_in.motor_up   = (ctrl_in.motor_dir == lcs_pkg::DIR_UP);
      rsp_in.motor_down = (ctrl_in.motor_dir == lcs_pkg::DIR_DOWN);
      rsp_in.door_open  = (ctrl_in.lift_mode == lcs_pkg::MODE_SERVICE);
      rsp_in.floor_now  = floor_in[1:0];
      rsp_in.mode       = ctrl_in.lift_mode;
      rsp_in.pending    = pending_wide[2:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            item_valid_ff <= 1'b1;
         end else if (advance) begin
            item_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.lift_mode    <= lcs_pkg::MODE_IDLE;
         ctrl_ff.motor_dir    <= lcs_pkg::DIR_STOP;
         ctrl_ff.prefer_up    <= 1'b1;
         ctrl_ff.door_counter <= 16'd0;
         floor_ff             <= FW'(1);
         requests_ff          <= '0;
      end else if (advance) begin
         ctrl_ff     <= ctrl_in;
         floor_ff    <= floor_in;
         requests_ff <= requests_in;
      end
   end

endmodule

`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for the lift controller scan unit with a predicting scoreboard.
`timescale 1ns / 1ps

class lift_scoreboard #(int FLOORS = 3);
   lcs_pkg::mode_type lift_mode;
   lcs_pkg::dir_type  motor_dir;
   logic [1:0]        floor_reg;
   logic              prefer_up;
   logic [15:0]       door_count;
   logic [2:0]        req_bits;
   logic [15:0]       hold_ticks;
   logic [9:0]        obstruct;
   lcs_pkg::rsp_type  expected_outputs [$];
   int                mismatches;
   int                checked;

   function new();
      lift_mode  = lcs_pkg::MODE_IDLE;
      motor_dir  = lcs_pkg::DIR_STOP;
      floor_reg  = 2'd1;
      prefer_up  = 1'b1;
      door_count = '0;
      req_bits   = '0;
      hold_ticks = lcs_pkg::DOOR_HOLD_RESET;
      obstruct   = lcs_pkg::OBSTRUCT_RESET;
      mismatches = 0;
      checked    = 0;
   endfunction

   function void write_register(logic [lcs_pkg::CSR_INDEX_WIDTH-1:0] index,
                                logic [lcs_pkg::CSR_DATA_WIDTH-1:0] data);
      if (index == lcs_pkg::CSR_DOOR_HOLD_TICKS)
         hold_ticks = data;
      else if (index == lcs_pkg::CSR_OBSTRUCT_DISTANCE)
         obstruct = data[9:0];
   endfunction

   function bit wanted(int f);
      if (f < 1 || f > FLOORS)
         return 1'b0;
      return req_bits[f-1];
   endfunction

   function void open_door();
      motor_dir = lcs_pkg::DIR_STOP;
      if (wanted(int'(floor_reg)) || int'(floor_reg) <= FLOORS)
         req_bits[int'(floor_reg) - 1] = 1'b0;
      lift_mode  = lcs_pkg::MODE_SERVICE;
      door_count = '0;
   endfunction

   // The current floor comes first, then the preferred direction, then the other one.
   function int choose_target();
      int f;
      int cur;
      cur = int'(floor_reg);
      if (wanted(cur))
         return cur;
      if (prefer_up) begin
         for (f = cur + 1; f <= FLOORS; f++)
            if (wanted(f)) return f;
         for (f = cur - 1; f >= 1; f--)
            if (wanted(f)) begin
               prefer_up = 1'b0;
               return f;
            end
      end else begin
         for (f = cur - 1; f >= 1; f--)
            if (wanted(f)) return f;
         for (f = cur + 1; f <= FLOORS; f++)
            if (wanted(f)) begin
               prefer_up = 1'b1;
               return f;
            end
      end
      return 0;
   endfunction

   function lcs_pkg::rsp_type advance_tick(lcs_pkg::req_type item);
      lcs_pkg::rsp_type o;
      bit      moved;
      int      i;
      int      cur;
      int      target;
      moved = 1'b0;
      if (item.request_valid && item.request_floor >= 1 && item.request_floor <= FLOORS)
         req_bits[item.request_floor - 1] = 1'b1;
      for (i = 0; i < lcs_pkg::SWITCH_COUNT && i < FLOORS; i++) begin
         if (item.floor_switches[i]) begin
            if (int'(floor_reg) != i + 1) begin
               floor_reg = 2'(i + 1);
               moved = 1'b1;
            end
            break;
         end
      end
      cur = int'(floor_reg);
      case (lift_mode)
         lcs_pkg::MODE_IDLE: begin
            target = choose_target();
            if (target != 0) begin
               if (target > cur) begin
                  lift_mode = lcs_pkg::MODE_UP;
                  motor_dir = lcs_pkg::DIR_UP;
               end else if (target < cur) begin
                  lift_mode = lcs_pkg::MODE_DOWN;
                  motor_dir = lcs_pkg::DIR_DOWN;
               end else begin
                  open_door();
               end
            end
         end
         lcs_pkg::MODE_UP: begin
            if (moved && wanted(cur)) begin
               open_door();
            end else if (cur == FLOORS) begin
               motor_dir = lcs_pkg::DIR_STOP;
               lift_mode = lcs_pkg::MODE_IDLE;
               prefer_up = 1'b0;
            end
         end
         lcs_pkg::MODE_DOWN: begin
            if (moved && wanted(cur)) begin
               open_door();
            end else if (cur == 1) begin
               motor_dir = lcs_pkg::DIR_STOP;
               lift_mode = lcs_pkg::MODE_IDLE;
               prefer_up = 1'b1;
            end
         end
         default: begin
            if (item.door_distance < obstruct) begin
               door_count = '0;
            end else begin
               if (door_count != lcs_pkg::COUNTER_MAX)
                  door_count = door_count + 16'd1;
               if (door_count >= hold_ticks)
                  lift_mode = lcs_pkg::MODE_IDLE;
            end
         end
      endcase
      o.motor_up   = (motor_dir == lcs_pkg::DIR_UP);
      o.motor_down = (motor_dir == lcs_pkg::DIR_DOWN);
      o.door_open  = (lift_mode == lcs_pkg::MODE_SERVICE);
      o.floor_now  = floor_reg;
      o.mode       = lift_mode;
      o.pending    = req_bits;
      return o;
   endfunction

   function void note_item(lcs_pkg::req_type item);
      expected_outputs.push_back(advance_tick(item));
   endfunction

   function int outstanding();
      return expected_outputs.size();
   endfunction

   task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      if (mismatches < 50)
         $display("mismatch at output %0d, %s: got %0h, expected %0h",
                  checked, what, got, want);
      mismatches++;
   endtask

   task check_result(lcs_pkg::rsp_type got);
      lcs_pkg::rsp_type want;
      checked++;
      if (expected_outputs.size() == 0) begin
         report_mismatch("output with no item waiting", 16'(got), '0);
         return;
      end
      want = expected_outputs.pop_front();
      if (got.motor_up !== want.motor_up)
         report_mismatch("motor_up", 16'(got.motor_up), 16'(want.motor_up));
      if (got.motor_down !== want.motor_down)
         report_mismatch("motor_down", 16'(got.motor_down), 16'(want.motor_down));
      if (got.door_open !== want.door_open)
         report_mismatch("door_open", 16'(got.door_open), 16'(want.door_open));
      if (got.floor_now !== want.floor_now)
         report_mismatch("floor_now", 16'(got.floor_now), 16'(want.floor_now));
      if (got.mode !== want.mode)
         report_mismatch("mode", 16'(got.mode), 16'(want.mode));
      if (got.pending !== want.pending)
         report_mismatch("pending", 16'(got.pending), 16'(want.pending));
   endtask
endclass

module tb;
   localparam int FLOORS = 3;
   localparam int STALL_LIMIT = 4000;
   localparam logic [lcs_pkg::CSR_INDEX_WIDTH-1:0] UNUSED_INDEX = 4'hF;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   lcs_pkg::req_type                    req_data = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   lcs_pkg::rsp_type                    rsp_data;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [lcs_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [lcs_pkg::CSR_DATA_WIDTH-1:0]  csr_data = '0;

   lift_scoreboard #(FLOORS) sb;
   bit calm = 1'b0;
   int cab_pos = 0;
   bit resync_cab = 1'b0;
   int items_sent = 0;
   int csr_writes = 0;
   int quiet_cycles = 0;

   lift_controller_scan_unit #(.FLOORS(FLOORS)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 28);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: nothing moved for %0d cycles", STALL_LIMIT);
            $display("** lift_controller_scan_unit: FAILED **");
            $finish;
         end
      end
   end

   function automatic lcs_pkg::req_type make_req(logic [2:0] sw, logic rv, logic [3:0] rf,
                                                 logic [9:0] distance);
      lcs_pkg::req_type t;
      t.floor_switches = sw;
      t.request_valid  = rv;
      t.request_floor  = rf;
      t.door_distance  = distance;
      return t;
   endfunction

   // The cab follows the predicted motor, so most ticks show a plausible journey.
   function automatic lcs_pkg::req_type random_tick();
      logic [2:0] sw;
      logic       rv;
      logic [3:0] rf;
      logic [9:0] distance;
      int         r;
      if (resync_cab) begin
         cab_pos = 2 * (int'(sb.floor_reg) - 1);
         resync_cab = 1'b0;
      end
      if (sb.motor_dir == lcs_pkg::DIR_UP && cab_pos < 2 * (FLOORS - 1) &&
          $urandom_range(1) == 1)
         cab_pos++;
      else if (sb.motor_dir == lcs_pkg::DIR_DOWN && cab_pos > 0 && $urandom_range(1) == 1)
         cab_pos--;
      if ($urandom_range(99) < 12) begin
         sw = 3'($urandom_range(7));
         resync_cab = 1'b1;
      end else if (cab_pos % 2 == 0) begin
         sw = 3'(1 << (cab_pos / 2));
      end else begin
         sw = '0;
      end
      rv = ($urandom_range(99) < 30);
      if (rv && $urandom_range(99) < 85)
         rf = 4'($urandom_range(FLOORS, 1));
      else
         rf = 4'($urandom_range(15));
      r = $urandom_range(99);
      if (r < 22 && sb.obstruct != 0)
         distance = 10'($urandom_range(int'(sb.obstruct) - 1));
      else if (r < 32)
         distance = 10'd999;
      else if (r < 40)
         distance = sb.obstruct;
      else
         distance = 10'($urandom_range(1023, int'(sb.obstruct)));
      return make_req(sw, rv, rf, distance);
   endfunction

   task automatic send_item(input lcs_pkg::req_type item);
      if (!calm)
         while ($urandom_range(99) < 28) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_item(item);
      items_sent++;
   endtask

   task automatic wait_for_results(input int settle);
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic configure(input logic [15:0] hold, input logic [15:0] obstruct_word,
                            input bit poke_unused);
      logic [lcs_pkg::CSR_INDEX_WIDTH-1:0] idx [$];
      logic [lcs_pkg::CSR_DATA_WIDTH-1:0]  val [$];
      if (poke_unused) begin
         idx.push_back(UNUSED_INDEX);
         val.push_back(16'($urandom));
      end
      idx.push_back(lcs_pkg::CSR_DOOR_HOLD_TICKS);
      val.push_back(hold);
      idx.push_back(lcs_pkg::CSR_OBSTRUCT_DISTANCE);
      val.push_back(obstruct_word);
      foreach (idx[k]) begin
         csr_valid <= 1'b1;
         csr_index <= idx[k];
         csr_data  <= val[k];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         sb.write_register(idx[k], val[k]);
         csr_writes++;
      end
      csr_valid <= 1'b0;
   endtask

   task automatic run_ticks(input int count, input int pause_at);
      int n;
      for (n = 0; n < count; n++) begin
         if (n == pause_at)
            wait_for_results(0);
         send_item(random_tick());
      end
   endtask

   initial begin
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: switch priority, ignored requests and door obstruction.
      send_item(make_req(3'd0, 1'b0, 4'd0, 10'd0));
      send_item(make_req(3'd7, 1'b1, 4'd0, 10'd1023));
      send_item(make_req(3'd4, 1'b1, 4'd15, 10'd999));
      send_item(make_req(3'd4, 1'b1, 4'd3, 10'd500));
      send_item(make_req(3'd4, 1'b0, 4'd0, 10'd0));
      send_item(make_req(3'd4, 1'b0, 4'd0, 10'd9));
      send_item(make_req(3'd4, 1'b0, 4'd0, 10'd10));
      wait_for_results(4);

      // A zero hold time closes the door on the first clear tick.
      configure(16'd0, 16'd10, 1'b0);
      send_item(make_req(3'd0, 1'b0, 4'd0, 10'd10));
      send_item(make_req(3'd0, 1'b1, 4'd1, 10'd0));
      send_item(make_req(3'd0, 1'b1, 4'd3, 10'd50));
      send_item(make_req(3'd2, 1'b0, 4'd0, 10'd50));
      send_item(make_req(3'd2, 1'b1, 4'd2, 10'd50));
      send_item(make_req(3'd1, 1'b0, 4'd0, 10'd50));
      send_item(make_req(3'd1, 1'b0, 4'd0, 10'd1023));
      send_item(make_req(3'd1, 1'b0, 4'd0, 10'd50));
      send_item(make_req(3'd2, 1'b0, 4'd0, 10'd50));
      send_item(make_req(3'd2, 1'b0, 4'd0, 10'd999));
      send_item(make_req(3'd2, 1'b0, 4'd0, 10'd50));
      send_item(make_req(3'd0, 1'b0, 4'd0, 10'd50));
      send_item(make_req(3'd6, 1'b0, 4'd0, 10'd50));
      send_item(make_req(3'd4, 1'b0, 4'd0, 10'd50));
      send_item(make_req(3'd4, 1'b0, 4'd0, 10'd50));
      send_item(make_req(3'd4, 1'b1, 4'd2, 10'd50));
      send_item(make_req(3'd1, 1'b0, 4'd0, 10'd50));
      send_item(make_req(3'd1, 1'b0, 4'd0, 10'd50));
      wait_for_results(4);

      configure(16'd1, {6'($urandom), 10'd0}, 1'b0);
      run_ticks(80, -1);
      wait_for_results(4);

      configure(16'hFFFF, 16'hFFFF, 1'b0);
      run_ticks(40, -1);
      wait_for_results(4);

      configure(16'($urandom_range(6, 2)), {6'($urandom), 10'd10}, 1'b0);
      calm = 1'b1;
      run_ticks(50, -1);
      calm = 1'b0;
      run_ticks(80, 30);
      wait_for_results(4);

      configure(16'd3, {6'($urandom), 10'($urandom_range(1022, 1))}, 1'b1);
      run_ticks(100, -1);
      wait_for_results(4);

      configure(16'($urandom_range(12, 1)), {6'($urandom), 10'd512}, 1'b0);
      run_ticks(100, -1);
      wait_for_results(8);

      $display("Run covered %0d control ticks, %0d checked outputs and %0d register writes,",
               items_sent, sb.checked, csr_writes);
      $display("from directed journeys and door timing extremes to random floor traffic.");
      if (sb.mismatches == 0) begin
         $display("** lift_controller_scan_unit: PASSED **");
      end else begin
         $display("%0d mismatches found", sb.mismatches);
         $display("** lift_controller_scan_unit: FAILED **");
      end
      $finish;
   end
endmodule

/* lift_controller_scan_unit.f */
hw/rtl/lcs_pkg.sv
hw/rtl/lcs_csr.sv
hw/rtl/lcs_step.sv
hw/rtl/lift_controller_scan_unit.sv
verif/tb.sv
